// ===== sv/esc_pkg.sv =====
package esc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_TEMP       = 3'd0;
  localparam logic [2:0] CFG_PRESS_LOW  = 3'd1;
  localparam logic [2:0] CFG_PRESS_HIGH = 3'd2;
  localparam logic [2:0] CFG_PRESS_NINE = 3'd3;
  localparam logic [2:0] CFG_HUM        = 3'd4;

  // divider: two quotient bits per stage, plus a sign stage on each side
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int REM_W     = 31;

  localparam int TEMP_LAT  = 3;
  localparam int PRESS_LAT = 8 + DIV_LAT + 6;
  localparam int HUM_LAT   = 10;
  localparam int FINE_DLY  = PRESS_LAT - 1;
  localparam int HUM_DLY   = PRESS_LAT - HUM_LAT;
  localparam int NSTAGE    = TEMP_LAT + PRESS_LAT + 1;

  localparam logic [31:0] HUM_CLAMP = 32'd419430400;
  localparam logic [16:0] HUM_MAX   = 17'd102400;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [63:0]      nq;
    logic [REM_W-1:0] dmag;
    logic             neg;
    logic             zero;
  } div_stage_t;

  typedef struct packed {
    logic [31:0] value;
    logic        valid;
  } press_res_t;

endpackage

// ===== sv/esc_mul64.sv =====
module esc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  // low 64 bits of a 64x64 product from three 32x32 partial products
  logic [63:0] ll_r;
  logic [31:0] lh_r;
  logic [31:0] hl_r;
  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
      lh_r <= 32'(a[31:0] * b[63:32]);
      hl_r <= 32'(a[63:32] * b[31:0]);
      p_r  <= ll_r + {lh_r + hl_r, 32'd0};
    end
  end

  assign p = p_r;

endmodule

// ===== sv/esc_sdiv.sv =====
module esc_sdiv
  import esc_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic [63:0]             num,
  input  logic signed [REM_W-1:0] den,
  output logic [63:0]             quo,
  output logic                    den_zero
);

  div_stage_t  st_r [DIV_STEPS+1];
  div_stage_t  pre;
  logic [63:0] quo_r;
  logic        zero_r;

  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t       o;
    logic [REM_W:0]   sh;
    o     = s;
    sh    = {s.rem, s.nq[63]};
    o.nq  = {s.nq[62:0], 1'b0};
    if (sh >= {1'b0, s.dmag}) begin
      o.rem   = REM_W'(sh - {1'b0, s.dmag});
      o.nq[0] = 1'b1;
    end else begin
      o.rem = sh[REM_W-1:0];
    end
    return o;
  endfunction

  always_comb begin
    pre.rem  = '0;
    pre.nq   = num[63] ? 64'd0 - num : num;
    pre.dmag = den[REM_W-1] ? REM_W'(0) - den : den;
    pre.neg  = num[63] ^ den[REM_W-1];
    pre.zero = (den == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= pre;
      for (int i = 1; i <= DIV_STEPS; i++) begin
        st_r[i] <= div_step(div_step(st_r[i-1]));
      end
      // most negative / -1 wraps back to itself here
      quo_r  <= st_r[DIV_STEPS].neg ? 64'd0 - st_r[DIV_STEPS].nq : st_r[DIV_STEPS].nq;
      zero_r <= st_r[DIV_STEPS].zero;
    end
  end

  assign quo      = quo_r;
  assign den_zero = zero_r;

endmodule

// ===== sv/esc_press.sv =====
module esc_press
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] fine,
  input  logic [19:0] raw_p,
  input  logic [63:0] calib_low,
  input  logic [63:0] calib_high,
  input  logic [15:0] calib_nine,
  output press_res_t  res
);

  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] v1;
  logic [63:0] m1, m2, m3, m4, m5, m6, m7, m8, m9, m10;
  logic [63:0] m2_d_r [2];
  logic [63:0] m3_d_r [2];
  logic [63:0] m10_d_r [2];
  logic [19:0] ap_d_r [5];
  logic [63:0] v2_r, x_r, nb_r;
  logic signed [REM_W-1:0] dv_r;
  logic [63:0] quo;
  logic        dz;
  logic [63:0] q13;
  logic [63:0] p_d_r [4];
  logic        dz_d_r [5];
  logic [63:0] s_r;
  logic [63:0] s_sh;
  press_res_t  res_r;

  assign p1 = {48'd0, calib_low[15:0]};
  assign p2 = 64'($signed(calib_low[31:16]));
  assign p3 = 64'($signed(calib_low[47:32]));
  assign p4 = 64'($signed(calib_low[63:48]));
  assign p5 = 64'($signed(calib_high[15:0]));
  assign p6 = 64'($signed(calib_high[31:16]));
  assign p7 = 64'($signed(calib_high[47:32]));
  assign p8 = 64'($signed(calib_high[63:48]));
  assign p9 = 64'($signed(calib_nine));

  assign v1 = 64'($signed(fine)) - 64'd128000;

  esc_mul64 u_mul_a (.clk, .en, .a(v1), .b(v1), .p(m1));
  esc_mul64 u_mul_b (.clk, .en, .a(v1), .b(p5), .p(m2));
  esc_mul64 u_mul_c (.clk, .en, .a(v1), .b(p2), .p(m3));
  esc_mul64 u_mul_d (.clk, .en, .a(m1), .b(p6), .p(m4));
  esc_mul64 u_mul_e (.clk, .en, .a(m1), .b(p3), .p(m5));
  esc_mul64 u_mul_f (.clk, .en, .a(x_r), .b(p1), .p(m6));
  esc_mul64 u_mul_g (.clk, .en, .a(nb_r), .b(64'd3125), .p(m7));

  esc_sdiv u_div (
    .clk,
    .en,
    .num      (m7),
    .den      (dv_r),
    .quo      (quo),
    .den_zero (dz)
  );

  assign q13 = 64'($signed(quo) >>> 13);

  esc_mul64 u_mul_h (.clk, .en, .a(q13), .b(q13), .p(m8));
  esc_mul64 u_mul_i (.clk, .en, .a(quo), .b(p8), .p(m10));
  esc_mul64 u_mul_j (.clk, .en, .a(m8), .b(p9), .p(m9));

  assign s_sh = 64'($signed(s_r) >>> 8);

  always_ff @(posedge clk) begin
    if (en) begin
      ap_d_r[0] <= raw_p;
      for (int i = 1; i < 5; i++) begin
        ap_d_r[i] <= ap_d_r[i-1];
      end
      m2_d_r[0] <= m2;
      m2_d_r[1] <= m2_d_r[0];
      m3_d_r[0] <= m3;
      m3_d_r[1] <= m3_d_r[0];

      v2_r <= m4 + (m2_d_r[1] << 17) + (p4 << 35);
      x_r  <= 64'h0000_8000_0000_0000 + 64'($signed(m5) >>> 8) + (m3_d_r[1] << 12);
      nb_r <= ((64'd1048576 - {44'd0, ap_d_r[4]}) << 31) - v2_r;
      dv_r <= $signed(m6[63:33]);

      p_d_r[0] <= quo;
      for (int i = 1; i < 4; i++) begin
        p_d_r[i] <= p_d_r[i-1];
      end
      dz_d_r[0] <= dz;
      for (int i = 1; i < 5; i++) begin
        dz_d_r[i] <= dz_d_r[i-1];
      end
      m10_d_r[0] <= m10;
      m10_d_r[1] <= m10_d_r[0];

      s_r <= p_d_r[3] + 64'($signed(m9) >>> 25) + 64'($signed(m10_d_r[1]) >>> 19);

      if (dz_d_r[4]) begin
        res_r.value <= '0;
        res_r.valid <= 1'b0;
      end else begin
        res_r.value <= s_sh[31:0] + {p7[27:0], 4'd0};
        res_r.valid <= 1'b1;
      end
    end
  end

  assign res = res_r;

endmodule

// ===== sv/esc_hum.sv =====
module esc_hum
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] fine,
  input  logic [15:0] raw_h,
  input  logic [63:0] calib,
  output logic [16:0] hum
);

  logic [31:0] h1, h2, h3, h4, h5, h6;
  logic [31:0] x;
  logic [31:0] ma_r, mb_r, mc_r, tt_r;
  logic [31:0] ha_r [5];
  logic [31:0] hb_r, hc_r, md_r, he_r, me_r, hf_r;
  logic [31:0] x2_r [3];
  logic [31:0] hs;
  logic [31:0] sq_r, mf_r;
  logic [31:0] x3;
  logic [16:0] hum_r;

  assign h1 = {24'd0, calib[7:0]};
  assign h2 = 32'($signed(calib[23:8]));
  assign h3 = {24'd0, calib[31:24]};
  assign h4 = 32'($signed(calib[43:32]));
  assign h5 = 32'($signed(calib[55:44]));
  assign h6 = 32'($signed(calib[63:56]));

  assign x  = fine - 32'd76800;
  assign hs = 32'($signed(x2_r[0]) >>> 15);
  assign x3 = x2_r[2] - 32'($signed(mf_r) >>> 4);

  // all intermediates wrap at 32 bits
  always_ff @(posedge clk) begin
    if (en) begin
      ma_r <= h5 * x;
      mb_r <= x * h6;
      mc_r <= x * h3;
      tt_r <= ({16'd0, raw_h} << 14) - (h4 << 20) + 32'd16384;

      ha_r[0] <= 32'($signed(tt_r - ma_r) >>> 15);
      hb_r    <= 32'($signed(mb_r) >>> 10);
      hc_r    <= 32'($signed(mc_r) >>> 11) + 32'd32768;
      for (int i = 1; i < 5; i++) begin
        ha_r[i] <= ha_r[i-1];
      end

      md_r <= hb_r * hc_r;
      he_r <= 32'($signed(md_r) >>> 10) + 32'd2097152;
      me_r <= he_r * h2;
      hf_r <= 32'($signed(me_r + 32'd8192) >>> 14);

      x2_r[0] <= ha_r[4] * hf_r;
      x2_r[1] <= x2_r[0];
      x2_r[2] <= x2_r[1];
      sq_r    <= hs * hs;
      mf_r    <= 32'($signed(sq_r) >>> 7) * h1;

      if (x3[31]) begin
        hum_r <= '0;
      end else if (x3 > HUM_CLAMP) begin
        hum_r <= HUM_MAX;
      end else begin
        hum_r <= x3[28:12];
      end
    end
  end

  assign hum = hum_r;

endmodule

// ===== sv/env_sensor_compensation.sv =====
// Integer compensation of one raw temperature/pressure/humidity sample per
// transfer, using calibration words written through the cfg_ port (all reset
// to zero). The datapath is a fixed 52-stage pipeline, and a sample may enter
// every cycle unless a stalled output holds it. The depth is set by the
// pressure path, mostly the signed 64-bit divider that resolves two
// quotient bits per stage (34 stages) and the chained 64-bit multiplies
// around it. A stalled output holds the whole pipeline; nothing is dropped.
// A zero pressure divisor gives pressure 0 with pressure_valid low.
// Calibration writes are accepted every cycle but must only be issued while
// the pipeline is empty.
module env_sensor_compensation
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] in_raw_pressure,
  input  logic [19:0] in_raw_temperature,
  input  logic [15:0] in_raw_humidity,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_fine_temperature,
  output logic [15:0] out_temperature_centi,
  output logic [31:0] out_pressure_q24_8,
  output logic        out_pressure_valid,
  output logic [16:0] out_humidity_q22_10,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [47:0] temp_calib_r;
  logic [63:0] press_low_r;
  logic [63:0] press_high_r;
  logic [15:0] press_nine_r;
  logic [63:0] hum_calib_r;

  logic [NSTAGE-1:0] vld_r;
  logic              en;

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;

  logic [19:0] ap0_r, at0_r, ap1_r, ap2_r, ap3_r;
  logic [15:0] ah0_r, ah1_r, ah2_r, ah3_r;
  logic signed [17:0] ta;
  logic signed [16:0] td;
  logic signed [33:0] tprod1_r, dd1_r;
  logic signed [21:0] bq;
  logic signed [22:0] a2_r;
  logic signed [37:0] bprod2_r;
  logic [31:0]        fine3_r;

  logic [31:0] fine_dly_r [FINE_DLY];
  logic [16:0] hum_dly_r [HUM_DLY];
  logic [16:0] hum13;
  press_res_t  press;

  logic signed [35:0] fs, tcw, tcs;
  logic [31:0] out_fine_r;
  logic [15:0] out_tc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_low_r  <= '0;
      press_high_r <= '0;
      press_nine_r <= '0;
      hum_calib_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TEMP:       temp_calib_r <= cfg_data[47:0];
        CFG_PRESS_LOW:  press_low_r  <= cfg_data;
        CFG_PRESS_HIGH: press_high_r <= cfg_data;
        CFG_PRESS_NINE: press_nine_r <= cfg_data[15:0];
        CFG_HUM:        hum_calib_r  <= cfg_data;
        default:        ;
      endcase
    end
  end

  // whole pipeline advances unless the output holds an untaken result
  assign en       = !vld_r[NSTAGE-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTAGE-2:0], in_valid};
    end
  end

  assign t1 = temp_calib_r[15:0];
  assign t2 = $signed(temp_calib_r[31:16]);
  assign t3 = $signed(temp_calib_r[47:32]);

  assign ta = $signed({1'b0, at0_r[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign td = $signed({1'b0, at0_r[19:4]}) - $signed({1'b0, t1});
  assign bq = 22'(dd1_r >>> 12);

  always_ff @(posedge clk) begin
    if (en) begin
      ap0_r <= in_raw_pressure;
      at0_r <= in_raw_temperature;
      ah0_r <= in_raw_humidity;

      tprod1_r <= ta * t2;
      dd1_r    <= td * td;
      ap1_r    <= ap0_r;
      ah1_r    <= ah0_r;

      a2_r     <= 23'(tprod1_r >>> 11);
      bprod2_r <= bq * t3;
      ap2_r    <= ap1_r;
      ah2_r    <= ah1_r;

      fine3_r <= 32'(a2_r) + 32'(bprod2_r >>> 14);
      ap3_r   <= ap2_r;
      ah3_r   <= ah2_r;
    end
  end

  esc_press u_press (
    .clk,
    .en,
    .fine       (fine3_r),
    .raw_p      (ap3_r),
    .calib_low  (press_low_r),
    .calib_high (press_high_r),
    .calib_nine (press_nine_r),
    .res        (press)
  );

  esc_hum u_hum (
    .clk,
    .en,
    .fine  (fine3_r),
    .raw_h (ah3_r),
    .calib (hum_calib_r),
    .hum   (hum13)
  );

  // centi-degrees from the delayed fine temperature, saturated to 16 bits
  assign fs  = 36'($signed(fine_dly_r[FINE_DLY-1]));
  assign tcw = (fs <<< 2) + fs + 36'sd128;
  assign tcs = tcw >>> 8;

  always_ff @(posedge clk) begin
    if (en) begin
      fine_dly_r[0] <= fine3_r;
      for (int i = 1; i < FINE_DLY; i++) begin
        fine_dly_r[i] <= fine_dly_r[i-1];
      end
      hum_dly_r[0] <= hum13;
      for (int i = 1; i < HUM_DLY; i++) begin
        hum_dly_r[i] <= hum_dly_r[i-1];
      end

      out_fine_r <= fine_dly_r[FINE_DLY-1];
      if (tcs > 36'sd32767) begin
        out_tc_r <= 16'h7fff;
      end else if (tcs < -36'sd32768) begin
        out_tc_r <= 16'h8000;
      end else begin
        out_tc_r <= tcs[15:0];
      end
    end
  end

  assign out_valid             = vld_r[NSTAGE-1];
  assign out_fine_temperature  = out_fine_r;
  assign out_temperature_centi = out_tc_r;
  assign out_pressure_q24_8    = press.value;
  assign out_pressure_valid    = press.valid;
  assign out_humidity_q22_10   = hum_dly_r[HUM_DLY-1];

  a_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pressure_valid || out_pressure_q24_8 == 32'd0))
    else $error("pressure nonzero with zero divisor");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_humidity_q22_10 <= HUM_MAX))
    else $error("humidity above clamp");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted sample not tracked in pipeline");

endmodule
